FILE: src/fmhq_pkg.sv
// ----------------------------------------------------------------------------
// fmhq_pkg
// Widths, register indexes, reset values and divider sizing for the fader
// to controller/note/bend quantizer.
// ----------------------------------------------------------------------------
package fmhq_pkg;

    localparam int IN_W       = 16;
    localparam int CC_W       = 7;
    localparam int NOTE_W     = 7;
    localparam int STICK_W    = 8;
    localparam int BEND_W     = 15;
    localparam int HELD_W     = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // map output span, wide enough for the bend span
    localparam int DIFF_W     = 16;
    // signed numerator and magnitude of the divider
    localparam int NUM_W      = 31;
    localparam int DIV_W      = NUM_W - 1;
    // signed denominator and its magnitude
    localparam int DEN_W      = IN_W + 1;
    localparam int DVS_W      = IN_W;
    // quotient bits resolved per cycle
    localparam int DIV_STEP   = 2;
    localparam int DIV_CYC    = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);
    // hysteresis bound arithmetic
    localparam int CTR_W      = 28;

    localparam logic signed [DIFF_W-1:0] BEND_SPAN = 16'sd16384;
    localparam logic signed [BEND_W-1:0] BEND_LOW  = -15'sd8192;

    localparam logic [IN_W-1:0]    RST_INPUT_MIN  = 16'd0;
    localparam logic [IN_W-1:0]    RST_INPUT_MAX  = 16'd65535;
    localparam logic [CC_W-1:0]    RST_CC_LOW     = 7'd0;
    localparam logic [CC_W-1:0]    RST_CC_HIGH    = 7'd127;
    localparam logic [NOTE_W-1:0]  RST_NOTE_LOW   = 7'd0;
    localparam logic [NOTE_W-1:0]  RST_NOTE_HIGH  = 7'd127;
    localparam logic [STICK_W-1:0] RST_STICKINESS = 8'd3;
    localparam logic [HELD_W-1:0]  RST_HELD       = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_MIN  = 3'd0,
        CFG_INPUT_MAX  = 3'd1,
        CFG_CC_LOW     = 3'd2,
        CFG_CC_HIGH    = 3'd3,
        CFG_NOTE_LOW   = 3'd4,
        CFG_NOTE_HIGH  = 3'd5,
        CFG_STICKINESS = 3'd6
    } t_cfg_idx;

endpackage

FILE: src/fader_to_midi_hysteresis_quantizer.sv
// ----------------------------------------------------------------------------
// fader_to_midi_hysteresis_quantizer
// Clamps a raw fader sample, maps it to controller, note and pitch bend
// values and applies note hysteresis, all through one shared signed divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  sample    in         i_valid / o_stall        i_sample
//  result    out        o_valid / i_stall        o_clamped o_cc_value o_note o_bend
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
//  one transaction in gives one result out; two more divisions are run when the
//  held note is above zero and the new note differs
//  every division runs in the shared 2-bit-per-cycle divider
//  o_stall is high from acceptance until the result enters the output register
//  the output register holds a result while i_stall is high
//  synchronous active-low reset restores the register defaults and no note
// ----------------------------------------------------------------------------
module fader_to_midi_hysteresis_quantizer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [fmhq_pkg::IN_W-1:0]             i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [fmhq_pkg::IN_W-1:0]             o_clamped,
    output logic [fmhq_pkg::CC_W-1:0]             o_cc_value,
    output logic [fmhq_pkg::NOTE_W-1:0]           o_note,
    output logic signed [fmhq_pkg::BEND_W-1:0]    o_bend,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fmhq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fmhq_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_POST,
        S_CTR,
        S_HYST,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_CC,
        OP_NOTE,
        OP_STEP,
        OP_STICK,
        OP_BEND
    } t_op;

    t_state r_state;
    t_op    r_op;

    // configuration
    logic [fmhq_pkg::IN_W-1:0]    r_in_min;
    logic [fmhq_pkg::IN_W-1:0]    r_in_max;
    logic [fmhq_pkg::CC_W-1:0]    r_cc_low;
    logic [fmhq_pkg::CC_W-1:0]    r_cc_high;
    logic [fmhq_pkg::NOTE_W-1:0]  r_note_low;
    logic [fmhq_pkg::NOTE_W-1:0]  r_note_high;
    logic [fmhq_pkg::STICK_W-1:0] r_stick;

    // item state
    logic [fmhq_pkg::HELD_W-1:0]        r_held;
    logic [fmhq_pkg::IN_W-1:0]          r_x;
    logic [fmhq_pkg::CC_W-1:0]          r_cc;
    logic [fmhq_pkg::NOTE_W-1:0]        r_nn;
    logic signed [fmhq_pkg::DEN_W-1:0]  r_s;
    logic signed [fmhq_pkg::DEN_W-1:0]  r_t;
    logic signed [fmhq_pkg::CTR_W-1:0]  r_ctr;
    logic signed [fmhq_pkg::CTR_W-1:0]  r_margin;
    logic [fmhq_pkg::BEND_W-1:0]        r_bend;

    // divider
    logic signed [fmhq_pkg::NUM_W-1:0]  r_num;
    logic signed [fmhq_pkg::DEN_W-1:0]  r_den;
    logic [fmhq_pkg::DIV_W-1:0]         r_quo;
    logic [fmhq_pkg::DVS_W-1:0]         r_rem;
    logic [fmhq_pkg::DVS_W-1:0]         r_dvs;
    logic                               r_neg;
    logic [fmhq_pkg::DIV_CNT_W-1:0]     r_cnt;

    // output register
    logic                               r_o_valid;
    logic [fmhq_pkg::IN_W-1:0]          r_o_clamped;
    logic [fmhq_pkg::CC_W-1:0]          r_o_cc;
    logic [fmhq_pkg::NOTE_W-1:0]        r_o_note;
    logic [fmhq_pkg::BEND_W-1:0]        r_o_bend;

    logic signed [fmhq_pkg::IN_W:0]                 x_off;
    logic signed [fmhq_pkg::IN_W:0]                 span;
    logic signed [fmhq_pkg::NOTE_W:0]               nspan;
    logic signed [fmhq_pkg::DIFF_W-1:0]             out_diff;
    logic signed [fmhq_pkg::IN_W+fmhq_pkg::DIFF_W:0] prod;
    logic signed [fmhq_pkg::NUM_W-1:0]              num_sel;
    logic signed [fmhq_pkg::DEN_W-1:0]              den_sel;
    logic [fmhq_pkg::NUM_W-1:0]                     num_abs;
    logic [fmhq_pkg::DEN_W-1:0]                     den_abs;

    logic [fmhq_pkg::DVS_W-1:0]   dv_rem   [0:fmhq_pkg::DIV_STEP];
    logic [fmhq_pkg::DIV_W-1:0]   dv_quo   [0:fmhq_pkg::DIV_STEP];
    logic [fmhq_pkg::DVS_W:0]     dv_sh    [0:fmhq_pkg::DIV_STEP-1];
    logic [fmhq_pkg::DVS_W+1:0]   dv_trial [0:fmhq_pkg::DIV_STEP-1];

    logic [fmhq_pkg::NUM_W-1:0]         q_mag;
    logic signed [fmhq_pkg::NUM_W-1:0]  quot;
    logic [fmhq_pkg::CC_W-1:0]          cc_sum;
    logic [fmhq_pkg::NOTE_W-1:0]        nn_sum;
    logic [fmhq_pkg::BEND_W-1:0]        bend_sum;
    logic                               held_pos;

    logic signed [fmhq_pkg::DEN_W-1:0]  s_half;
    logic signed [fmhq_pkg::NOTE_W+1:0] note_off;
    logic signed [fmhq_pkg::CTR_W-1:0]  ctr_calc;
    logic signed [fmhq_pkg::CTR_W-1:0]  margin_calc;
    logic signed [fmhq_pkg::CTR_W-1:0]  upper;
    logic signed [fmhq_pkg::CTR_W-1:0]  lower;
    logic signed [fmhq_pkg::CTR_W-1:0]  x_wide;

    logic                               in_take;
    logic                               out_free;
    logic [fmhq_pkg::IN_W-1:0]          clamp_x;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        priority if (i_sample < r_in_min) begin
            clamp_x = r_in_min;
        end else if (i_sample > r_in_max) begin
            clamp_x = r_in_max;
        end else begin
            clamp_x = i_sample;
        end
    end

    // operand selection and product for the map numerators
    assign x_off = $signed({1'b0, r_x}) - $signed({1'b0, r_in_min});
    assign span  = $signed({1'b0, r_in_max}) - $signed({1'b0, r_in_min});
    assign nspan = $signed({1'b0, r_note_high}) - $signed({1'b0, r_note_low});

    always_comb begin
        unique case (r_op)
            OP_CC: begin
                out_diff = $signed({{(fmhq_pkg::DIFF_W-fmhq_pkg::CC_W){1'b0}}, r_cc_high})
                         - $signed({{(fmhq_pkg::DIFF_W-fmhq_pkg::CC_W){1'b0}}, r_cc_low});
            end
            OP_NOTE: begin
                out_diff = fmhq_pkg::DIFF_W'(nspan);
            end
            default: begin
                out_diff = fmhq_pkg::BEND_SPAN;
            end
        endcase
    end

    assign prod = x_off * out_diff;

    always_comb begin
        unique case (r_op)
            OP_STEP: begin
                num_sel = fmhq_pkg::NUM_W'(span);
                den_sel = fmhq_pkg::DEN_W'(nspan);
            end
            OP_STICK: begin
                num_sel = fmhq_pkg::NUM_W'(r_s);
                den_sel = $signed({{(fmhq_pkg::DEN_W-fmhq_pkg::STICK_W){1'b0}}, r_stick});
            end
            default: begin
                num_sel = prod[fmhq_pkg::NUM_W-1:0];
                den_sel = span;
            end
        endcase
    end

    assign num_abs = r_num[fmhq_pkg::NUM_W-1] ? -r_num : r_num;
    assign den_abs = r_den[fmhq_pkg::DEN_W-1] ? -r_den : r_den;

    // restoring divider, DIV_STEP quotient bits per cycle
    always_comb begin
        dv_rem[0] = r_rem;
        dv_quo[0] = r_quo;
        for (int k = 0; k < fmhq_pkg::DIV_STEP; k++) begin
            dv_sh[k]      = {dv_rem[k], dv_quo[k][fmhq_pkg::DIV_W-1]};
            dv_trial[k]   = {1'b0, dv_sh[k]} - {2'b0, r_dvs};
            dv_quo[k+1]   = {dv_quo[k][fmhq_pkg::DIV_W-2:0], ~dv_trial[k][fmhq_pkg::DVS_W+1]};
            dv_rem[k+1]   = dv_trial[k][fmhq_pkg::DVS_W+1] ? dv_sh[k][fmhq_pkg::DVS_W-1:0]
                                                           : dv_trial[k][fmhq_pkg::DVS_W-1:0];
        end
    end

    // signed quotient, zero on a zero divisor
    assign q_mag = {1'b0, r_quo};
    always_comb begin
        if (r_dvs == '0) begin
            quot = '0;
        end else if (r_neg) begin
            quot = -$signed(q_mag);
        end else begin
            quot = $signed(q_mag);
        end
    end

    assign cc_sum   = quot[fmhq_pkg::CC_W-1:0] + r_cc_low;
    assign nn_sum   = quot[fmhq_pkg::NOTE_W-1:0] + r_note_low;
    assign bend_sum = quot[fmhq_pkg::BEND_W-1:0] + fmhq_pkg::BEND_LOW;
    assign held_pos = !r_held[fmhq_pkg::HELD_W-1] && (r_held != '0);

    // hysteresis bounds
    assign s_half      = (r_s + $signed({{(fmhq_pkg::DEN_W-1){1'b0}}, r_s[fmhq_pkg::DEN_W-1]}))
                         >>> 1;
    assign note_off    = $signed({2'b0, r_held[fmhq_pkg::NOTE_W-1:0]})
                       - $signed({2'b0, r_note_low});
    assign ctr_calc    = fmhq_pkg::CTR_W'(r_s) * fmhq_pkg::CTR_W'(note_off)
                       + fmhq_pkg::CTR_W'(s_half);
    assign margin_calc = fmhq_pkg::CTR_W'(s_half) + fmhq_pkg::CTR_W'(r_t);
    assign upper       = r_ctr + r_margin;
    assign lower       = r_ctr - r_margin;
    assign x_wide      = $signed({{(fmhq_pkg::CTR_W-fmhq_pkg::IN_W){1'b0}}, r_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CC;
            r_o_valid   <= 1'b0;
            r_held      <= fmhq_pkg::RST_HELD;
            r_in_min    <= fmhq_pkg::RST_INPUT_MIN;
            r_in_max    <= fmhq_pkg::RST_INPUT_MAX;
            r_cc_low    <= fmhq_pkg::RST_CC_LOW;
            r_cc_high   <= fmhq_pkg::RST_CC_HIGH;
            r_note_low  <= fmhq_pkg::RST_NOTE_LOW;
            r_note_high <= fmhq_pkg::RST_NOTE_HIGH;
            r_stick     <= fmhq_pkg::RST_STICKINESS;
        end else begin
            if (i_cfg_valid) begin
                unique case (fmhq_pkg::t_cfg_idx'(i_cfg_index))
                    fmhq_pkg::CFG_INPUT_MIN:  r_in_min    <= i_cfg_data[fmhq_pkg::IN_W-1:0];
                    fmhq_pkg::CFG_INPUT_MAX:  r_in_max    <= i_cfg_data[fmhq_pkg::IN_W-1:0];
                    fmhq_pkg::CFG_CC_LOW:     r_cc_low    <= i_cfg_data[fmhq_pkg::CC_W-1:0];
                    fmhq_pkg::CFG_CC_HIGH:    r_cc_high   <= i_cfg_data[fmhq_pkg::CC_W-1:0];
                    fmhq_pkg::CFG_NOTE_LOW:   r_note_low  <= i_cfg_data[fmhq_pkg::NOTE_W-1:0];
                    fmhq_pkg::CFG_NOTE_HIGH:  r_note_high <= i_cfg_data[fmhq_pkg::NOTE_W-1:0];
                    fmhq_pkg::CFG_STICKINESS: r_stick     <= i_cfg_data[fmhq_pkg::STICK_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_x     <= clamp_x;
                        r_op    <= OP_CC;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num   <= num_sel;
                    r_den   <= den_sel;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_neg   <= r_num[fmhq_pkg::NUM_W-1] ^ r_den[fmhq_pkg::DEN_W-1];
                    r_quo   <= num_abs[fmhq_pkg::DIV_W-1:0];
                    r_dvs   <= den_abs[fmhq_pkg::DVS_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= fmhq_pkg::DIV_CNT_W'(fmhq_pkg::DIV_CYC - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= dv_quo[fmhq_pkg::DIV_STEP];
                    r_rem <= dv_rem[fmhq_pkg::DIV_STEP];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    unique case (r_op)
                        OP_CC: begin
                            r_cc    <= cc_sum;
                            r_op    <= OP_NOTE;
                            r_state <= S_MUL;
                        end
                        OP_NOTE: begin
                            r_nn <= nn_sum;
                            if (held_pos && (nn_sum != r_held[fmhq_pkg::NOTE_W-1:0])) begin
                                r_op <= OP_STEP;
                            end else begin
                                r_held <= {1'b0, nn_sum};
                                r_op   <= OP_BEND;
                            end
                            r_state <= S_MUL;
                        end
                        OP_STEP: begin
                            r_s     <= quot[fmhq_pkg::DEN_W-1:0];
                            r_op    <= OP_STICK;
                            r_state <= S_MUL;
                        end
                        OP_STICK: begin
                            r_t     <= quot[fmhq_pkg::DEN_W-1:0];
                            r_state <= S_CTR;
                        end
                        OP_BEND: begin
                            r_bend  <= bend_sum;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_CTR: begin
                    r_ctr    <= ctr_calc;
                    r_margin <= margin_calc;
                    r_state  <= S_HYST;
                end
                S_HYST: begin
                    if (r_nn > r_held[fmhq_pkg::NOTE_W-1:0]) begin
                        if (x_wide > upper) begin
                            r_held <= {1'b0, r_nn};
                        end
                    end else if (x_wide < lower) begin
                        r_held <= {1'b0, r_nn};
                    end
                    r_op    <= OP_BEND;
                    r_state <= S_MUL;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_clamped <= r_x;
                        r_o_cc      <= r_cc;
                        r_o_note    <= r_held[fmhq_pkg::NOTE_W-1:0];
                        r_o_bend    <= r_bend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_clamped   = r_o_clamped;
    assign o_cc_value  = r_o_cc;
    assign o_note      = r_o_note;
    assign o_bend      = $signed(r_o_bend);

    // a result only appears after the output step
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

    // an accepted transaction always starts with the controller map
    a_start_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ((r_state == S_MUL) && (r_op == OP_CC)))
        else $error("accepted transaction did not start the controller map");

    // once a result is out the held note is a real note
    a_held_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !r_held[fmhq_pkg::HELD_W-1])
        else $error("held note still empty after a result");

    // hysteresis bounds are only worked out when a note is held
    a_hyst_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CTR) |-> held_pos)
        else $error("hysteresis check without a held note");

endmodule

FILE: sim/fader_to_midi_hysteresis_quantizer_checker.sv
// ----------------------------------------------------------------------------
// fader_to_midi_hysteresis_quantizer_checker
// Watches the sample, result and register channels of the fader quantizer.
// Keeps its own copy of the calibration and the held note, works out the
// clamped, controller, note and bend values of every accepted sample and
// compares them in order with the results the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fader_to_midi_hysteresis_quantizer_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  i_in_stall,
    input  logic [fmhq_pkg::IN_W-1:0]             i_sample,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic [fmhq_pkg::IN_W-1:0]             i_clamped,
    input  logic [fmhq_pkg::CC_W-1:0]             i_cc_value,
    input  logic [fmhq_pkg::NOTE_W-1:0]           i_note,
    input  logic signed [fmhq_pkg::BEND_W-1:0]    i_bend,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [fmhq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fmhq_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_held_count
);

    typedef struct packed {
        logic [fmhq_pkg::IN_W-1:0]          clamped;
        logic [fmhq_pkg::CC_W-1:0]          cc_value;
        logic [fmhq_pkg::NOTE_W-1:0]        note;
        logic signed [fmhq_pkg::BEND_W-1:0] bend;
    } t_fader_result;

    t_fader_result expected_q[$];

    logic [fmhq_pkg::IN_W-1:0]           in_min;
    logic [fmhq_pkg::IN_W-1:0]           in_max;
    logic [fmhq_pkg::CC_W-1:0]           cc_lo;
    logic [fmhq_pkg::CC_W-1:0]           cc_hi;
    logic [fmhq_pkg::NOTE_W-1:0]         nt_lo;
    logic [fmhq_pkg::NOTE_W-1:0]         nt_hi;
    logic [fmhq_pkg::STICK_W-1:0]        stick;
    logic signed [fmhq_pkg::HELD_W-1:0]  held;

    int fails   = 0;
    int checked = 0;
    int holds   = 0;

    function automatic longint ratio(input longint num, input longint den);
        return (den == 0) ? 0 : num / den;
    endfunction

    function automatic longint span_map(input longint x, input longint lo, input longint hi,
                                        input longint out_lo, input longint out_hi);
        return ratio((x - lo) * (out_hi - out_lo), hi - lo) + out_lo;
    endfunction

    function automatic t_fader_result quantize(input logic [fmhq_pkg::IN_W-1:0] raw);
        longint lo, hi, nlo, nhi, x, cc, nn, bend, prev, step, centre, margin;
        t_fader_result r;
        lo   = in_min;
        hi   = in_max;
        nlo  = nt_lo;
        nhi  = nt_hi;
        x    = raw;
        prev = held;
        // lower limit wins when the calibration is inverted
        if (x < lo) begin
            x = lo;
        end else if (x > hi) begin
            x = hi;
        end
        cc = span_map(x, lo, hi, cc_lo, cc_hi);
        nn = span_map(x, lo, hi, nlo, nhi);
        if (prev > 0 && nn != prev) begin
            step   = ratio(hi - lo, nhi - nlo);
            centre = step * (prev - nlo) + step / 2;
            margin = step / 2 + ratio(step, stick);
            if ((nn > prev && x > centre + margin) || (nn < prev && x < centre - margin)) begin
                held = nn[fmhq_pkg::HELD_W-1:0];
            end else begin
                holds++;
            end
        end else begin
            held = nn[fmhq_pkg::HELD_W-1:0];
        end
        bend = span_map(x, lo, hi, -8192, 8192);
        r.clamped  = x[fmhq_pkg::IN_W-1:0];
        r.cc_value = cc[fmhq_pkg::CC_W-1:0];
        r.note     = held[fmhq_pkg::NOTE_W-1:0];
        r.bend     = bend[fmhq_pkg::BEND_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_fader_result want;
        if (!i_rst_n) begin
            in_min = fmhq_pkg::RST_INPUT_MIN;
            in_max = fmhq_pkg::RST_INPUT_MAX;
            cc_lo  = fmhq_pkg::RST_CC_LOW;
            cc_hi  = fmhq_pkg::RST_CC_HIGH;
            nt_lo  = fmhq_pkg::RST_NOTE_LOW;
            nt_hi  = fmhq_pkg::RST_NOTE_HIGH;
            stick  = fmhq_pkg::RST_STICKINESS;
            held   = fmhq_pkg::RST_HELD;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fmhq_pkg::CFG_INPUT_MIN:  in_min = i_cfg_data;
                    fmhq_pkg::CFG_INPUT_MAX:  in_max = i_cfg_data;
                    fmhq_pkg::CFG_CC_LOW:     cc_lo  = i_cfg_data[fmhq_pkg::CC_W-1:0];
                    fmhq_pkg::CFG_CC_HIGH:    cc_hi  = i_cfg_data[fmhq_pkg::CC_W-1:0];
                    fmhq_pkg::CFG_NOTE_LOW:   nt_lo  = i_cfg_data[fmhq_pkg::NOTE_W-1:0];
                    fmhq_pkg::CFG_NOTE_HIGH:  nt_hi  = i_cfg_data[fmhq_pkg::NOTE_W-1:0];
                    fmhq_pkg::CFG_STICKINESS: stick  = i_cfg_data[fmhq_pkg::STICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no sample pending, expected none, actual %0d",
                             $time, i_clamped);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("clamped", want.clamped, i_clamped);
                    check_field("cc_value", want.cc_value, i_cc_value);
                    check_field("note", want.note, i_note);
                    check_field("bend", want.bend, i_bend);
                    checked++;
                end
            end
            if (i_valid && !i_in_stall) begin
                expected_q.push_back(quantize(i_sample));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_held_count <= holds;
    end

endmodule

FILE: sim/fader_to_midi_hysteresis_quantizer_tb.sv
// ----------------------------------------------------------------------------
// fader_to_midi_hysteresis_quantizer_tb
// Drives fader samples and calibration writes into the quantizer: a directed
// pass over range ends, hysteresis edges, inverted and empty calibration and
// oversized register writes, then random calibrations with slow fader walks
// and jumps, random idle gaps on both channels and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fader_to_midi_hysteresis_quantizer_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int PHASE_ITEMS   = 100;
    localparam logic [fmhq_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic [fmhq_pkg::IN_W-1:0]            i_sample    = '0;
    logic                                 i_stall     = 1'b0;
    logic                                 i_cfg_valid = 1'b0;
    logic [fmhq_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [fmhq_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                                 o_stall;
    logic                                 o_valid;
    logic [fmhq_pkg::IN_W-1:0]            o_clamped;
    logic [fmhq_pkg::CC_W-1:0]            o_cc_value;
    logic [fmhq_pkg::NOTE_W-1:0]          o_note;
    logic signed [fmhq_pkg::BEND_W-1:0]   o_bend;
    logic                                 o_cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int held_count;

    bit hold_req   = 1'b0;
    bit burst      = 1'b0;
    int stall_left = 0;
    int sent       = 0;
    int writes     = 0;
    int cur_min, cur_max, cur_nlo, cur_nhi;

    fader_to_midi_hysteresis_quantizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_clamped   (o_clamped),
        .o_cc_value  (o_cc_value),
        .o_note      (o_note),
        .o_bend      (o_bend),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fader_to_midi_hysteresis_quantizer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_clamped    (o_clamped),
        .i_cc_value   (o_cc_value),
        .i_note       (o_note),
        .i_bend       (o_bend),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_held_count (held_count)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("fader_to_midi_hysteresis_quantizer test failed");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  = 1'b0;
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    task automatic send_sample(input logic [fmhq_pkg::IN_W-1:0] value);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_sample = value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [fmhq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fmhq_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        writes++;
        case (idx)
            fmhq_pkg::CFG_INPUT_MIN: cur_min = data;
            fmhq_pkg::CFG_INPUT_MAX: cur_max = data;
            fmhq_pkg::CFG_NOTE_LOW:  cur_nlo = data & 127;
            fmhq_pkg::CFG_NOTE_HIGH: cur_nhi = data & 127;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_setup(input int in_lo, input int in_hi, input int c_lo, input int c_hi,
                               input int n_lo, input int n_hi, input int stk);
        write_reg(fmhq_pkg::CFG_INPUT_MIN, fmhq_pkg::CFG_DATA_W'(in_lo));
        write_reg(fmhq_pkg::CFG_INPUT_MAX, fmhq_pkg::CFG_DATA_W'(in_hi));
        write_reg(fmhq_pkg::CFG_CC_LOW, fmhq_pkg::CFG_DATA_W'(c_lo));
        write_reg(fmhq_pkg::CFG_CC_HIGH, fmhq_pkg::CFG_DATA_W'(c_hi));
        write_reg(fmhq_pkg::CFG_NOTE_LOW, fmhq_pkg::CFG_DATA_W'(n_lo));
        write_reg(fmhq_pkg::CFG_NOTE_HIGH, fmhq_pkg::CFG_DATA_W'(n_hi));
        write_reg(fmhq_pkg::CFG_STICKINESS, fmhq_pkg::CFG_DATA_W'(stk));
    endtask

    function automatic int pick_edge();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_setup();
        int a, b, nlo, nhi, stk;
        if ($urandom_range(0, 9) < 7) begin
            a   = $urandom_range(0, 40000);
            b   = a + $urandom_range(128, 65535 - a);
            nlo = $urandom_range(0, 100);
            nhi = $urandom_range(nlo + 1, 127);
            write_setup(a, b, $urandom_range(0, 127), $urandom_range(0, 127), nlo, nhi,
                        $urandom_range(1, 255));
        end else begin
            // degenerate corners: inverted or empty span, flat notes, no stickiness
            a = pick_edge();
            b = ($urandom_range(0, 4) == 0) ? a : pick_edge();
            nlo = $urandom_range(0, 65535);
            nhi = ($urandom_range(0, 3) == 0) ? nlo : $urandom_range(0, 65535);
            stk = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
            write_setup(a, b, $urandom_range(0, 65535), $urandom_range(0, 65535), nlo, nhi, stk);
        end
    endtask

    // slow fader walks around note boundaries, with jumps and range edges mixed in
    task automatic run_random(input int count);
        int lo, hi, notes, step, pos, r, j;
        lo    = (cur_min < cur_max) ? cur_min : cur_max;
        hi    = (cur_min < cur_max) ? cur_max : cur_min;
        notes = (cur_nhi > cur_nlo) ? cur_nhi - cur_nlo : cur_nlo - cur_nhi;
        step  = (hi - lo) / (notes + 1) + 1;
        pos   = $urandom_range(lo, hi);
        for (j = 0; j < count; j++) begin
            if (j % 40 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                pos = pos + int'($urandom_range(0, 2 * step)) - step;
            end else if (r < 85) begin
                pos = $urandom_range(0, 65535);
            end else if (r < 95) begin
                case ($urandom_range(0, 3))
                    0:       pos = lo - 1;
                    1:       pos = lo;
                    2:       pos = hi;
                    default: pos = hi + 1;
                endcase
            end else begin
                pos = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            end
            if (pos < 0) begin
                pos = 0;
            end else if (pos > 65535) begin
                pos = 65535;
            end
            send_sample(pos[fmhq_pkg::IN_W-1:0]);
        end
        burst = 1'b0;
    endtask

    initial begin : stimulus
        logic [fmhq_pkg::IN_W-1:0] default_walk [13] = '{
            16'd0, 16'd1000, 16'd1100, 16'd1300, 16'd1000, 16'd800, 16'hFFFF,
            16'd32767, 16'd32768, 16'hAAAA, 16'h5555, 16'd0, 16'd1
        };
        logic [fmhq_pkg::IN_W-1:0] inverted_set [5] = '{
            16'd0, 16'd30000, 16'hFFFF, 16'd39999, 16'd40000
        };
        logic [fmhq_pkg::IN_W-1:0] empty_set [3]    = '{16'd0, 16'd1234, 16'hFFFF};
        logic [fmhq_pkg::IN_W-1:0] wide_set [4]     = '{16'd0, 16'hFFFF, 16'd20000, 16'd20300};
        int p;

        cur_min = fmhq_pkg::RST_INPUT_MIN;
        cur_max = fmhq_pkg::RST_INPUT_MAX;
        cur_nlo = fmhq_pkg::RST_NOTE_LOW;
        cur_nhi = fmhq_pkg::RST_NOTE_HIGH;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset calibration: first note from no note, climb out of note zero,
        // held moves inside the band and moves past it both ways
        foreach (default_walk[k]) send_sample(default_walk[k]);

        wait_idle();
        write_setup(40000, 20000, 0, 127, 0, 127, 3);
        foreach (inverted_set[k]) send_sample(inverted_set[k]);

        wait_idle();
        write_setup(1234, 1234, 127, 0, 60, 60, 0);
        foreach (empty_set[k]) send_sample(empty_set[k]);

        // oversized data is cut to the register width, unmapped index is dropped
        wait_idle();
        write_reg(fmhq_pkg::CFG_INPUT_MIN, 16'h0000);
        write_reg(fmhq_pkg::CFG_INPUT_MAX, 16'hFFFF);
        write_reg(fmhq_pkg::CFG_CC_LOW, 16'hFFFF);
        write_reg(fmhq_pkg::CFG_CC_HIGH, 16'hFF80);
        write_reg(fmhq_pkg::CFG_NOTE_LOW, 16'hFF85);
        write_reg(fmhq_pkg::CFG_NOTE_HIGH, 16'hFFFF);
        write_reg(fmhq_pkg::CFG_STICKINESS, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'h1234);
        foreach (wide_set[k]) send_sample(wide_set[k]);

        for (p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
            wait_idle();
            random_setup();
            if (p == 2) begin
                hold_req = 1'b1;
            end
            run_random(PHASE_ITEMS);
        end
        wait_idle();

        $display("%0d samples sent across %0d register writes, %0d results compared",
                 sent, writes, checked);
        $display("%0d note changes were held back by the hysteresis band", held_count);
        if (fail_count == 0 && pending == 0) begin
            $display("fader_to_midi_hysteresis_quantizer test passed");
        end else begin
            $display("fader_to_midi_hysteresis_quantizer test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/fmhq_pkg.sv
src/fader_to_midi_hysteresis_quantizer.sv
sim/fader_to_midi_hysteresis_quantizer_checker.sv
sim/fader_to_midi_hysteresis_quantizer_tb.sv
